@@ hdl/psip_pkg.sv @@
`timescale 1ns / 1ps
// Shared constants and register codes of the parallel-section prefilter.
package psip_pkg;

   localparam int SAMPLE_W = 24;
   localparam int OUT_W = 32;
   localparam int HIST_W = 40;
   localparam int HFRAC = 14;
   localparam int COEF_FIELD_W = 16;
   localparam int COEFS_PER_SEC = 4;
   localparam int NUM_SEC_REGS = 4;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W = 64;
   localparam int SEC_COUNT_W = 4;

   localparam int DIGIT_BITS = 10;
   localparam int NDIGITS = (HIST_W + DIGIT_BITS - 1) / DIGIT_BITS;
   localparam int DIGIT_CNT_W = (NDIGITS > 1) ? $clog2(NDIGITS) : 1;

   localparam logic [CSR_INDEX_W-1:0] CSR_FILTER_MODE = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MEAN_OFFSET = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SECTIONS_IN_USE = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SECTION0_COEFS = 3'd3;

   localparam int COEF_A_NEWER = 0;
   localparam int COEF_A_OLDER = 1;
   localparam int COEF_G_NEW = 2;
   localparam int COEF_G_PREV = 3;

endpackage

@@ hdl/parallel_section_iir_prefilter_unit.sv @@
`timescale 1ns / 1ps
// Top level of the parallel-section recursive prefilter for seismic samples.
//
// One request beat carries a 24-bit sample; one response beat returns the demeaned
// sample, or in filter mode the rounded and saturated sum of the active second-order
// sections. A single digit-serial multiplier forms all products, ten history bits per
// cycle, and each product starts with a load. For each active section a filtered
// sample runs four products and a new-value step; a pass-through sample, or filter
// mode with no active section, goes straight to the output step. A finished result
// waits in the output register, so the next sample is taken meanwhile.
module parallel_section_iir_prefilter_unit
   import psip_pkg::*;
#(
   parameter int SECTIONS = 4,
   parameter int COEF_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [SAMPLE_W-1:0]    req_sample_value,
   input  logic                          req_restart,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [OUT_W-1:0]       rsp_filtered_value,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [CSR_INDEX_W-1:0]        csr_index,
   input  logic [CSR_DATA_W-1:0]         csr_data
);

   localparam int CFRAC = COEF_BITS - 2;
   localparam int SEC_W = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;
   localparam int ACC_W = COEF_BITS + HIST_W + $clog2(SECTIONS) + 2;
   localparam logic signed [ACC_W-1:0] REC_ROUND = ACC_W'(1) << (CFRAC - 1);
   localparam logic signed [ACC_W-1:0] OUT_ROUND = ACC_W'(1) << (CFRAC + HFRAC - 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_MUL,
      ST_NV,
      ST_FIN
   } state_type;

   typedef enum logic [1:0] {
      OP_OLDER,
      OP_NEWER,
      OP_GAIN_NEW,
      OP_GAIN_PREV
   } op_type;

   state_type                     state_ff;
   op_type                        op_ff;
   logic [SEC_W-1:0]              sec_ff;
   logic                          pass_ff;
   logic signed [SAMPLE_W:0]      x_ff;
   logic signed [SAMPLE_W:0]      x_in;
   logic signed [ACC_W-1:0]       rec_ff;
   logic signed [ACC_W-1:0]       out_ff;
   logic signed [HIST_W-1:0]      prev_ff;
   logic signed [HIST_W-1:0]      nv_ff;
   logic signed [HIST_W-1:0]      nv_in;
   logic [SECTIONS-1:0]           valid_ff;
   logic                          rsp_valid_ff;
   logic signed [OUT_W-1:0]       rsp_value_ff;

   logic                          filter_mode_ff;
   logic signed [SAMPLE_W-1:0]    mean_ff;
   logic [2:0]                    sections_ff;
   logic signed [COEF_BITS-1:0]   coef_ff [SECTIONS][COEFS_PER_SEC];

   logic signed [HIST_W-1:0]      older_ff [SECTIONS];
   logic signed [HIST_W-1:0]      newer_ff [SECTIONS];
   logic signed [HIST_W-1:0]      older_rd;
   logic signed [HIST_W-1:0]      newer_rd;

   logic [SEC_COUNT_W-1:0]        n_eff;
   logic                          last_sec;
   logic                          req_accept;
   logic                          rsp_free;

   logic                          mul_load;
   logic signed [COEF_BITS-1:0]   mul_coef;
   logic signed [HIST_W-1:0]      mul_operand;
   logic signed [ACC_W-1:0]       mul_init;
   logic signed [ACC_W-1:0]       mul_acc;
   logic                          mul_done;

   logic signed [ACC_W:0]         nv_sum;
   logic                          nv_ovf;
   logic signed [ACC_W-1:0]       y_sh;
   logic                          y_ovf;
   logic signed [OUT_W-1:0]       y_in;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         filter_mode_ff <= 1'b1;
         mean_ff <= '0;
         sections_ff <= '0;
         for (int s = 0; s < SECTIONS; s++) begin
            for (int k = 0; k < COEFS_PER_SEC; k++) begin
               coef_ff[s][k] <= '0;
            end
         end
      end else if (csr_valid) begin
         if (csr_index == CSR_FILTER_MODE) begin
            filter_mode_ff <= csr_data[0];
         end
         if (csr_index == CSR_MEAN_OFFSET) begin
            mean_ff <= csr_data[SAMPLE_W-1:0];
         end
         if (csr_index == CSR_SECTIONS_IN_USE) begin
            sections_ff <= csr_data[2:0];
         end
         for (int s = 0; s < SECTIONS; s++) begin
            if (s < NUM_SEC_REGS) begin
               if (csr_index == CSR_SECTION0_COEFS + CSR_INDEX_W'(s)) begin
                  for (int k = 0; k < COEFS_PER_SEC; k++) begin
                     coef_ff[s][k] <= csr_data[COEF_FIELD_W*k +: COEF_BITS];
                  end
               end
            end
         end
      end
   end

   assign n_eff = ({1'b0, sections_ff} > SEC_COUNT_W'(SECTIONS)) ?
                  SEC_COUNT_W'(SECTIONS) : {1'b0, sections_ff};
   assign last_sec = (SEC_COUNT_W'(sec_ff) + 1'b1) == n_eff;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_accept = req_valid & ~req_stall;
   assign rsp_free = ~rsp_valid_ff | ~rsp_stall;

   assign x_in = (SAMPLE_W + 1)'(req_sample_value) - (SAMPLE_W + 1)'(mean_ff);

   assign older_rd = valid_ff[sec_ff] ? older_ff[sec_ff] : '0;
   assign newer_rd = valid_ff[sec_ff] ? newer_ff[sec_ff] : '0;

   always_comb begin
      case (op_ff)
         OP_OLDER: begin
            mul_coef = coef_ff[sec_ff][COEF_A_OLDER];
            mul_operand = older_rd;
            mul_init = REC_ROUND;
         end
         OP_NEWER: begin
            mul_coef = coef_ff[sec_ff][COEF_A_NEWER];
            mul_operand = prev_ff;
            mul_init = rec_ff;
         end
         OP_GAIN_NEW: begin
            mul_coef = coef_ff[sec_ff][COEF_G_NEW];
            mul_operand = nv_ff;
            mul_init = out_ff;
         end
         OP_GAIN_PREV: begin
            mul_coef = coef_ff[sec_ff][COEF_G_PREV];
            mul_operand = prev_ff;
            mul_init = out_ff;
         end
         default: begin
            mul_coef = '0;
            mul_operand = '0;
            mul_init = '0;
         end
      endcase
   end

   assign mul_load = (state_ff == ST_LOAD);

   psip_digit_mac #(
      .COEF_BITS(COEF_BITS),
      .ACC_W(ACC_W)
   ) u_mac (
      .clock(clock),
      .reset(reset),
      .load(mul_load),
      .coef(mul_coef),
      .operand(mul_operand),
      .init(mul_init),
      .acc(mul_acc),
      .done(mul_done)
   );

   // The recursion sum already holds its rounding offset from the start of the section.
   assign nv_sum = (ACC_W + 1)'(rec_ff >>> CFRAC) + ((ACC_W + 1)'(x_ff) <<< HFRAC);
   assign nv_ovf = ~((&nv_sum[ACC_W:HIST_W-1]) | ~(|nv_sum[ACC_W:HIST_W-1]));
   assign nv_in = nv_ovf ? (nv_sum[ACC_W] ? {1'b1, {(HIST_W - 1){1'b0}}} :
                                            {1'b0, {(HIST_W - 1){1'b1}}}) :
                           nv_sum[HIST_W-1:0];

   assign y_sh = out_ff >>> (CFRAC + HFRAC);
   assign y_ovf = ~((&y_sh[ACC_W-1:OUT_W-1]) | ~(|y_sh[ACC_W-1:OUT_W-1]));

   always_comb begin
      if (pass_ff) begin
         y_in = OUT_W'(x_ff);
      end else if (y_ovf) begin
         y_in = y_sh[ACC_W-1] ? {1'b1, {(OUT_W - 1){1'b0}}} : {1'b0, {(OUT_W - 1){1'b1}}};
      end else begin
         y_in = y_sh[OUT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_NV) begin
         older_ff[sec_ff] <= prev_ff;
         newer_ff[sec_ff] <= nv_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         op_ff <= OP_OLDER;
         sec_ff <= '0;
         valid_ff <= '0;
         rsp_valid_ff <= 1'b0;
         pass_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall && (state_ff != ST_FIN)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_accept) begin
                  x_ff <= x_in;
                  out_ff <= OUT_ROUND;
                  sec_ff <= '0;
                  op_ff <= OP_OLDER;
                  pass_ff <= ~filter_mode_ff;
                  if (req_restart) begin
                     valid_ff <= '0;
                  end
                  if (filter_mode_ff && (n_eff != '0)) begin
                     state_ff <= ST_LOAD;
                  end else begin
                     state_ff <= ST_FIN;
                  end
               end
            end
            ST_LOAD: begin
               if (op_ff == OP_OLDER) begin
                  prev_ff <= newer_rd;
               end
               state_ff <= ST_MUL;
            end
            ST_MUL: begin
               if (mul_done) begin
                  case (op_ff)
                     OP_OLDER: begin
                        rec_ff <= mul_acc;
                        op_ff <= OP_NEWER;
                        state_ff <= ST_LOAD;
                     end
                     OP_NEWER: begin
                        rec_ff <= mul_acc;
                        state_ff <= ST_NV;
                     end
                     OP_GAIN_NEW: begin
                        out_ff <= mul_acc;
                        op_ff <= OP_GAIN_PREV;
                        state_ff <= ST_LOAD;
                     end
                     OP_GAIN_PREV: begin
                        out_ff <= mul_acc;
                        op_ff <= OP_OLDER;
                        if (last_sec) begin
                           state_ff <= ST_FIN;
                        end else begin
                           sec_ff <= sec_ff + 1'b1;
                           state_ff <= ST_LOAD;
                        end
                     end
                     default: begin
                        state_ff <= ST_IDLE;
                     end
                  endcase
               end
            end
            ST_NV: begin
               nv_ff <= nv_in;
               valid_ff[sec_ff] <= 1'b1;
               op_ff <= OP_GAIN_NEW;
               state_ff <= ST_LOAD;
            end
            ST_FIN: begin
               if (rsp_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_value_ff <= y_in;
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_filtered_value = rsp_value_ff;

endmodule

@@ hdl/psip_digit_mac.sv @@
`timescale 1ns / 1ps
// Digit-serial multiply-accumulate: coefficient times history word, one digit per cycle.
module psip_digit_mac
   import psip_pkg::*;
#(
   parameter int COEF_BITS = 16,
   parameter int ACC_W = 58
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        load,
   input  logic signed [COEF_BITS-1:0] coef,
   input  logic signed [HIST_W-1:0]    operand,
   input  logic signed [ACC_W-1:0]     init,
   output logic signed [ACC_W-1:0]     acc,
   output logic                        done
);

   localparam int PP_W = COEF_BITS + DIGIT_BITS + 1;

   logic [HIST_W-1:0]            opnd_ff;
   logic signed [COEF_BITS-1:0]  coef_ff;
   logic signed [ACC_W-1:0]      acc_ff;
   logic [DIGIT_CNT_W-1:0]       cnt_ff;
   logic                         run_ff;
   logic                         done_ff;
   logic                         last_digit;
   logic signed [DIGIT_BITS:0]   digit;
   logic signed [PP_W-1:0]       pp;
   logic signed [ACC_W-1:0]      pp_ext;
   logic signed [ACC_W-1:0]      acc_in;

   // The top digit carries the sign of the history word; the others are unsigned.
   assign last_digit = (cnt_ff == DIGIT_CNT_W'(NDIGITS - 1));
   assign digit = {last_digit & opnd_ff[DIGIT_BITS-1], opnd_ff[DIGIT_BITS-1:0]};
   assign pp = coef_ff * digit;
   assign pp_ext = ACC_W'(pp);
   assign acc_in = acc_ff + (pp_ext <<< (cnt_ff * DIGIT_BITS));

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (load) begin
            run_ff <= 1'b1;
            cnt_ff <= '0;
         end else if (run_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (last_digit) begin
               run_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         opnd_ff <= operand;
         coef_ff <= coef;
         acc_ff <= init;
      end else if (run_ff) begin
         opnd_ff <= opnd_ff >> DIGIT_BITS;
         acc_ff <= acc_in;
      end
   end

   assign acc = acc_ff;
   assign done = done_ff;

endmodule
